### hdl/gnd_pkg.sv
`default_nettype none
package gnd_pkg;

    localparam int NUM_DENOMS_DEF  = 6;
    localparam int AMOUNT_BITS_DEF = 24;
    localparam int VALUE_BITS      = 16;
    localparam int COUNT_REG_BITS  = 3;

    localparam int CFG_DENOM_COUNT = 0;
    localparam int CFG_DENOM_BASE  = 1;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### hdl/greedy_note_dispenser.sv
// Operation: sorts the note table into the cell chain, then per table entry until the
// remainder is zero: a check step, a bit-serial divide, and an emit step for a
// nonzero quotient that may stall on out_stall.
// Throughput: one item at a time; a zero amount is taken without a payout.
// Reset: asynchronous, active low; clears control state, all config regs to 1.
`default_nettype none
module greedy_note_dispenser #(
    parameter int NUM_DENOMS  = gnd_pkg::NUM_DENOMS_DEF,
    parameter int AMOUNT_BITS = gnd_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [$clog2(NUM_DENOMS+1)-1:0]    cfg_index,
    input  wire logic [gnd_pkg::VALUE_BITS-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [AMOUNT_BITS-1:0]             amount,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [gnd_pkg::VALUE_BITS-1:0]          note_value,
    output logic [AMOUNT_BITS-1:0]                  note_count,
    output logic                                    last
);
    import gnd_pkg::*;

    localparam int DEPTH     = NUM_DENOMS + 1;
    localparam int SORT_LEN  = 2 * DEPTH;
    localparam int IDX_BITS  = $clog2(NUM_DENOMS + 1);
    localparam int DI_BITS   = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
    localparam int CNT_BITS  = $clog2(SORT_LEN + 1);
    localparam logic [COUNT_REG_BITS-1:0] MAX_USED =
        (NUM_DENOMS > 7) ? COUNT_REG_BITS'(7) : COUNT_REG_BITS'(NUM_DENOMS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SORT  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [CNT_BITS-1:0]       cnt_reg, cnt_next;
    logic [AMOUNT_BITS-1:0]    rem_reg, rem_next;
    logic [COUNT_REG_BITS-1:0] denom_count_reg;
    logic [VALUE_BITS-1:0]     denom_reg [NUM_DENOMS];

    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]     note_value_reg;
    logic [AMOUNT_BITS-1:0]    note_count_reg;
    logic                      last_reg;
    logic                      load_out;

    logic [COUNT_REG_BITS-1:0] used3;
    logic [CNT_BITS-1:0]       used_n;
    logic                      feed_valid;
    logic [VALUE_BITS-1:0]     feed_value;
    logic                      accept;
    logic                      div_start;
    logic                      div_done;
    logic [AMOUNT_BITS-1:0]    div_q;
    logic [VALUE_BITS-1:0]     div_r;
    cell_ctrl_t                cell_ctrl;

    logic                      hold_valid [DEPTH];
    logic [VALUE_BITS-1:0]     hold_value [DEPTH];
    logic                      pass_valid [DEPTH];
    logic [VALUE_BITS-1:0]     pass_value [DEPTH];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            denom_count_reg <= COUNT_REG_BITS'(1);
            for (int i = 0; i < NUM_DENOMS; i++)
            begin
                denom_reg[i] <= VALUE_BITS'(1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == IDX_BITS'(CFG_DENOM_COUNT))
            begin
                denom_count_reg <= cfg_data[COUNT_REG_BITS-1:0];
            end
            else if (cfg_index <= IDX_BITS'(NUM_DENOMS))
            begin
                denom_reg[DI_BITS'(cfg_index - IDX_BITS'(CFG_DENOM_BASE))] <= cfg_data;
            end
        end
    end

    always_comb
    begin
        used3 = denom_count_reg;
        if (used3 == '0)
        begin
            used3 = COUNT_REG_BITS'(1);
        end
        else if (used3 > MAX_USED)
        begin
            used3 = MAX_USED;
        end
    end

    assign used_n     = CNT_BITS'(used3);
    assign feed_valid = (state_reg == S_SORT) && (cnt_reg <= used_n);
    assign feed_value = (cnt_reg < used_n) ? denom_reg[cnt_reg[DI_BITS-1:0]]
                                           : VALUE_BITS'(1);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                  cin_valid;
            logic [VALUE_BITS-1:0] cin_value;
            logic                  cnb_valid;
            logic [VALUE_BITS-1:0] cnb_value;

            if (g == 0)
            begin : g_head
                assign cin_valid = feed_valid;
                assign cin_value = feed_value;
            end
            else
            begin : g_body
                assign cin_valid = pass_valid[g-1];
                assign cin_value = pass_value[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign cnb_valid = 1'b0;
                assign cnb_value = '0;
            end
            else
            begin : g_link
                assign cnb_valid = hold_valid[g+1];
                assign cnb_value = hold_value[g+1];
            end

            gnd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .in_valid   (cin_valid),
                .in_value   (cin_value),
                .nb_valid   (cnb_valid),
                .nb_value   (cnb_value),
                .hold_valid (hold_valid[g]),
                .hold_value (hold_value[g]),
                .pass_valid (pass_valid[g]),
                .pass_value (pass_value[g])
            );
        end
    endgenerate

    gnd_divider #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rem_reg),
        .divisor   (hold_value[0]),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && out_stall;
        load_out        = 1'b0;
        div_start       = 1'b0;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.shift = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (amount != '0))
                begin
                    rem_next        = amount;
                    cnt_next        = '0;
                    cell_ctrl.clear = 1'b1;
                    state_next      = S_SORT;
                end
            end
            S_SORT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(SORT_LEN - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (hold_value[0] == '0)
                begin
                    cell_ctrl.shift = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (div_q == '0)
                begin
                    cell_ctrl.shift = 1'b1;
                    state_next      = S_CHECK;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    load_out        = 1'b1;
                    out_valid_next  = 1'b1;
                    rem_next        = AMOUNT_BITS'(div_r);
                    cell_ctrl.shift = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            note_value_reg <= hold_value[0];
            note_count_reg <= div_q;
            last_reg       <= (div_r == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign note_value = note_value_reg;
    assign note_count = note_count_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

### hdl/gnd_cell.sv
`default_nettype none
module gnd_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gnd_pkg::cell_ctrl_t        ctrl,
    input  wire logic                       in_valid,
    input  wire logic [gnd_pkg::VALUE_BITS-1:0] in_value,
    input  wire logic                       nb_valid,
    input  wire logic [gnd_pkg::VALUE_BITS-1:0] nb_value,
    output logic                            hold_valid,
    output logic [gnd_pkg::VALUE_BITS-1:0]  hold_value,
    output logic                            pass_valid,
    output logic [gnd_pkg::VALUE_BITS-1:0]  pass_value
);
    import gnd_pkg::*;

    logic                  hold_valid_reg, hold_valid_next;
    logic                  pass_valid_reg, pass_valid_next;
    logic [VALUE_BITS-1:0] hold_value_reg, hold_value_next;
    logic [VALUE_BITS-1:0] pass_value_reg, pass_value_next;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        pass_valid_next = 1'b0;
        pass_value_next = pass_value_reg;
        priority if (ctrl.clear)
        begin
            hold_valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            hold_valid_next = nb_valid;
            hold_value_next = nb_value;
        end
        else if (in_valid)
        begin
            if (!hold_valid_reg)
            begin
                hold_valid_next = 1'b1;
                hold_value_next = in_value;
            end
            else if (in_value > hold_value_reg)
            begin
                // keep the larger value, push the smaller one on
                hold_value_next = in_value;
                pass_valid_next = 1'b1;
                pass_value_next = hold_value_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
                pass_value_next = in_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_value_reg <= hold_value_next;
        pass_value_reg <= pass_value_next;
    end

    assign hold_valid = hold_valid_reg;
    assign hold_value = hold_value_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_value = pass_value_reg;

endmodule
`default_nettype wire

### hdl/gnd_divider.sv
`default_nettype none
module gnd_divider #(
    parameter int AMOUNT_BITS = gnd_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [AMOUNT_BITS-1:0]        dividend,
    input  wire logic [gnd_pkg::VALUE_BITS-1:0] divisor,
    output logic                               done,
    output logic [AMOUNT_BITS-1:0]             quotient,
    output logic [gnd_pkg::VALUE_BITS-1:0]     remainder
);
    import gnd_pkg::*;

    localparam int STEP_BITS = $clog2(AMOUNT_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [AMOUNT_BITS-1:0] quot_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] divisor_reg;
    logic [VALUE_BITS:0]   trial;
    logic                  fits;

    assign trial = {rem_reg, quot_reg[AMOUNT_BITS-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(AMOUNT_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quot_reg    <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= VALUE_BITS'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[VALUE_BITS-1:0];
            end
            quot_reg <= {quot_reg[AMOUNT_BITS-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

### tb/greedy_note_dispenser_checker.sv
`default_nettype none
module greedy_note_dispenser_checker #(
    parameter int NDEN  = gnd_pkg::NUM_DENOMS_DEF,
    parameter int ABITS = gnd_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [$clog2(NDEN+1)-1:0]     cfg_index,
    input  wire logic [gnd_pkg::VALUE_BITS-1:0] cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [ABITS-1:0]              amount,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [gnd_pkg::VALUE_BITS-1:0] note_value,
    input  wire logic [ABITS-1:0]              note_count,
    input  wire logic                          last,
    output int                                 fail_count,
    output int                                 owed_count,
    output int                                 amounts_taken,
    output int                                 notes_seen
);
    import gnd_pkg::*;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [ABITS-1:0]      count;
        logic                  last;
    } payout_t;

    logic [COUNT_REG_BITS-1:0] count_reg;
    logic [VALUE_BITS-1:0]     note_reg [NDEN];
    payout_t                   payout_q [$];
    int                        errors;
    int                        taken;
    int                        seen;

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] payout mismatch: %s", $time, what);
    endtask

    // sort descending with ties kept, append a unit note unless the smallest is one, then divide down
    function automatic void plan_payout(input logic [ABITS-1:0] amt);
        logic [VALUE_BITS-1:0] ladder [NDEN+1];
        logic [VALUE_BITS-1:0] d;
        logic [ABITS-1:0]      rest;
        logic [ABITS-1:0]      notes;
        payout_t               entry;
        int                    n;
        int                    j;
        if (amt == '0)
            return;
        if (count_reg == 0)
            n = 1;
        else if (int'(count_reg) > NDEN)
            n = NDEN;
        else
            n = int'(count_reg);
        for (int i = 0; i < n; i++)
        begin
            d = note_reg[i];
            j = i;
            while (j > 0 && ladder[j-1] < d)
            begin
                ladder[j] = ladder[j-1];
                j--;
            end
            ladder[j] = d;
        end
        if (ladder[n-1] != 1)
        begin
            ladder[n] = 1;
            n++;
        end
        rest = amt;
        for (int i = 0; i < n; i++)
        begin
            if (ladder[i] != 0)
            begin
                notes = rest / ladder[i];
                rest  = rest % ladder[i];
                if (notes != 0)
                begin
                    entry.value = ladder[i];
                    entry.count = notes;
                    entry.last  = (rest == 0);
                    payout_q.insert(payout_q.size(), entry);
                end
            end
        end
    endfunction

    task automatic check_note();
        payout_t got;
        payout_t want;
        got = {note_value, note_count, last};
        if (payout_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected note value %0d count %0d last %0b",
                                      got.value, got.count, got.last));
        end
        else
        begin
            want = payout_q.pop_front();
            if (got.value !== want.value || got.count !== want.count
                    || got.last !== want.last)
                report_mismatch($sformatf(
                    "note %0d: got value %0d count %0d last %0b, want %0d %0d %0b",
                    seen, got.value, got.count, got.last,
                    want.value, want.count, want.last));
        end
    endtask

    initial
    begin
        errors = 0;
        taken  = 0;
        seen   = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = 1;
            for (int i = 0; i < NDEN; i++)
                note_reg[i] = 1;
            payout_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DENOM_COUNT)
                    count_reg = cfg_data[COUNT_REG_BITS-1:0];
                else if (cfg_index >= CFG_DENOM_BASE && cfg_index < CFG_DENOM_BASE + NDEN)
                    note_reg[cfg_index - CFG_DENOM_BASE] = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                taken++;
                plan_payout(amount);
            end
            if (out_valid && !out_stall)
            begin
                seen++;
                check_note();
            end
        end
        fail_count    <= errors;
        owed_count    <= payout_q.size();
        amounts_taken <= taken;
        notes_seen    <= seen;
    end

endmodule
`default_nettype wire

### tb/greedy_note_dispenser_tb.sv
`default_nettype none
module greedy_note_dispenser_tb;
    import gnd_pkg::*;

    localparam int NDEN            = NUM_DENOMS_DEF;
    localparam int ABITS           = AMOUNT_BITS_DEF;
    localparam int IDX_BITS        = $clog2(NDEN + 1);
    localparam int CFG_SPARE_INDEX = CFG_DENOM_BASE + NDEN;
    localparam int SETTLE_CYCLES   = 250;
    localparam int HOLD_CYCLES     = 1500;
    localparam int RANDOM_ROUNDS   = 8;
    localparam int ROUND_ITEMS     = 55;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [VALUE_BITS-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [ABITS-1:0]      amount;
    logic                  out_valid;
    logic                  out_stall;
    logic [VALUE_BITS-1:0] note_value;
    logic [ABITS-1:0]      note_count;
    logic                  last;

    int                    fail_count;
    int                    owed_count;
    int                    amounts_taken;
    int                    notes_seen;
    int                    settings_used;
    bit                    gaps_on;
    bit                    holding;
    event                  hold_go;
    logic [VALUE_BITS-1:0] notes_cfg [NDEN];

    greedy_note_dispenser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .note_value (note_value),
        .note_count (note_count),
        .last       (last)
    );

    greedy_note_dispenser_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .amount        (amount),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .note_value    (note_value),
        .note_count    (note_count),
        .last          (last),
        .fail_count    (fail_count),
        .owed_count    (owed_count),
        .amounts_taken (amounts_taken),
        .notes_seen    (notes_seen)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        out_stall <= holding || (gaps_on && $urandom_range(0, 99) < 10);

    initial
    begin
        forever
        begin
            @(hold_go);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            holding = 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic write_reg(input int idx, input logic [VALUE_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[IDX_BITS-1:0];
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [VALUE_BITS-1:0] count_word);
        write_reg(CFG_DENOM_COUNT, count_word);
        for (int i = 0; i < NDEN; i++)
            write_reg(CFG_DENOM_BASE + i, notes_cfg[i]);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_amount(input logic [ABITS-1:0] value);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        amount   <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // drain every owed note, then let the last amount run to completion
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (owed_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ABITS-1:0] random_amount();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 8)
            return '1;
        if (pick < 45)
            return ABITS'($urandom_range(1, 2000));
        if (pick < 60)
            return ABITS'($urandom_range(1, 200000));
        return ABITS'($urandom);
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_note(input int slot);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        if (pick < 18 && slot > 0)
            return notes_cfg[$urandom_range(0, slot - 1)];
        if (pick < 40)
            return VALUE_BITS'($urandom_range(1, 10));
        if (pick < 70)
            return VALUE_BITS'($urandom_range(2, 500));
        if (pick < 78)
            return '1;
        return VALUE_BITS'($urandom);
    endfunction

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        amount        = '0;
        out_stall     = 1'b0;
        gaps_on       = 1'b1;
        holding       = 1'b0;
        settings_used = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        send_amount(24'd0);
        send_amount(24'd1);
        send_amount(24'hFFFFFF);
        send_amount(24'h800000);
        send_amount(24'h555555);
        settle();

        notes_cfg = '{16'd20, 16'd1, 16'd100, 16'd5, 16'd50, 16'd10};
        apply_setting(16'd6);
        send_amount(24'd187);
        send_amount(24'd100);
        send_amount(24'd99);
        send_amount(24'hFFFFFF);
        send_amount(24'd0);
        send_amount(24'd6);
        settle();

        // saturated count, zero note, repeated note, no unit note
        notes_cfg = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'd3, 16'h8000, 16'd2};
        apply_setting(16'd7);
        send_amount(24'd98309);
        send_amount(24'd1);
        send_amount(24'hFFFFFF);
        send_amount(24'd65534);
        send_amount(24'd131070);
        settle();

        // count field of zero, spare index ignored
        write_reg(CFG_DENOM_COUNT, 16'h0008);
        write_reg(CFG_DENOM_BASE, 16'd7);
        write_reg(CFG_SPARE_INDEX, 16'hFFFF);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
        send_amount(24'd6);
        send_amount(24'd7);
        send_amount(24'd15);
        settle();

        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            for (int i = 0; i < NDEN; i++)
                notes_cfg[i] = random_note(i);
            apply_setting(VALUE_BITS'($urandom));
            gaps_on = (r != 2);
            if (r == 4)
                -> hold_go;
            for (int k = 0; k < ROUND_ITEMS; k++)
                send_amount(random_amount());
            settle();
        end
        gaps_on = 1'b1;

        $display("Run covered %0d amounts over %0d note settings, %0d note results checked",
                 amounts_taken, settings_used, notes_seen);
        if (fail_count == 0 && owed_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
